FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/fnvht_pkg.sv
package fnvht_pkg;

   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

   typedef enum logic [2:0] {
      ST_HIT      = 3'd0,
      ST_MISS     = 3'd1,
      ST_INSERTED = 3'd2,
      ST_UPDATED  = 3'd3,
      ST_ZERO     = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   typedef enum logic [0:0] {
      OP_GET = 1'b0,
      OP_SET = 1'b1
   } opcode_type;

   // Front state: hashing bytes one per cycle.
   typedef enum logic [1:0] {
      FS_IDLE,
      FS_HASH,
      FS_PUSH
   } front_state_type;

   // Back state machine.
   typedef enum logic [3:0] {
      BS_CLEAR,
      BS_IDLE,
      BS_DECIDE,
      BS_PROBE_RD,
      BS_PROBE_CHK,
      BS_GROW_RD,
      BS_GROW_CHK,
      BS_GROW_HASH,
      BS_GROW_PRB_RD,
      BS_GROW_PRB_CHK,
      BS_GROW_NEXT,
      BS_REPLY
   } back_state_type;

   // Classified request passed from front to back.
   typedef struct packed {
      logic        is_set;
      logic        zero_val;
      logic [63:0] key;
      logic [3:0]  len;
      logic [31:0] value;
      logic [63:0] hash;
   } job_type;

   // One step of FNV-1a over a byte. The 64-bit prime is 2^40 + 0x1B3,
   // so the product mod 2^64 is a handful of shifted adds.
   function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return ((x << 40) + (x << 8)) + ((x << 7) + (x << 5)) + ((x << 4) + ((x << 1) + x));
   endfunction

endpackage

FILE: hw/rtl/fnv1a_linear_probe_hash_table.sv
// Flow: the front hashes the key byte by byte and queues the job; the back then reads
// and checks one probed slot at a time, while a refused set skips the probe altogether.
// A growing set first reads every old slot, rehashing each full one into the other bank.
// The front takes a new beat once its last job is queued, and holds off while the queue is full.
// Reset: synchronous; count to zero, capacity to initial, then both banks swept clear.
// Results leave on rsp_done for one cycle; the receiver cannot stall.
module fnv1a_linear_probe_hash_table #(
   parameter int MAX_CAPACITY     = 1024,
   parameter int INITIAL_CAPACITY = 256,
   parameter int VALUE_WIDTH      = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [63:0] req_key_bytes,
   input  logic [3:0]  req_key_len,
   input  logic [31:0] req_value_in,
   output logic        rsp_done,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_value_out,
   output logic [10:0] rsp_count_out
);

   logic               job_valid;
   logic               pop;
   fnvht_pkg::job_type job;

   // front: request capture and byte-serial hash
   fnvht_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_key_bytes (req_key_bytes),
      .req_key_len   (req_key_len),
      .req_value_in  (req_value_in),
      .pop           (pop),
      .job_valid     (job_valid),
      .job           (job)
   );

   // back: probing, growth, reply beat
   fnvht_back #(
      .MAX_CAPACITY     (MAX_CAPACITY),
      .INITIAL_CAPACITY (INITIAL_CAPACITY),
      .VALUE_WIDTH      (VALUE_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job           (job),
      .pop           (pop),
      .rsp_done      (rsp_done),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_count_out (rsp_count_out)
   );

endmodule

FILE: hw/rtl/fnvht_front.sv
// Front: latches a request, clamps and masks the key, hashes one byte per cycle,
// and pushes the classified job into a two-entry queue.
module fnvht_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_opcode,
   input  logic [63:0]          req_key_bytes,
   input  logic [3:0]           req_key_len,
   input  logic [31:0]          req_value_in,
   input  logic                 pop,
   output logic                 job_valid,
   output fnvht_pkg::job_type   job
);

   fnvht_pkg::front_state_type state_ff, state_in;
   fnvht_pkg::job_type cur_ff, cur_in;
   logic [3:0] idx_ff, idx_in;

   fnvht_pkg::job_type q_ff [2];
   logic q_wr_ff, q_rd_ff;
   logic [1:0] q_cnt_ff;
   logic push;

   logic [3:0]  len_c;
   logic [63:0] key_c;
   logic [63:0] mul_c;

   always_comb begin
      len_c = (req_key_len > 4'd8) ? 4'd8 : req_key_len;
      key_c = req_key_bytes;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) >= len_c) begin
            key_c[8*i +: 8] = 8'd0;
         end
      end
   end

   // multiplier is combinational; its output is stored straight into the running hash
   assign mul_c = fnvht_pkg::fnv_step(cur_ff.hash, cur_ff.key[{idx_ff[2:0], 3'b000} +: 8]);

   assign busy = (state_ff != fnvht_pkg::FS_IDLE);
   assign push = (state_ff == fnvht_pkg::FS_PUSH) && (q_cnt_ff != 2'd2);

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         fnvht_pkg::FS_IDLE: begin
            if (start) begin
               cur_in.is_set   = (req_opcode == fnvht_pkg::OP_SET);
               cur_in.zero_val = (req_value_in == 32'd0);
               cur_in.key      = key_c;
               cur_in.len      = len_c;
               cur_in.value    = req_value_in;
               cur_in.hash     = fnvht_pkg::FNV_BASIS;
               idx_in          = 4'd0;
               state_in        = fnvht_pkg::FS_HASH;
            end
         end
         fnvht_pkg::FS_HASH: begin
            if (idx_ff >= cur_ff.len) begin
               state_in = fnvht_pkg::FS_PUSH;
            end else begin
               cur_in.hash = mul_c;
               idx_in      = idx_ff + 4'd1;
            end
         end
         fnvht_pkg::FS_PUSH: begin
            if (push) begin
               state_in = fnvht_pkg::FS_IDLE;
            end
         end
         default: state_in = fnvht_pkg::FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fnvht_pkg::FS_IDLE;
         q_wr_ff  <= 1'b0;
         q_rd_ff  <= 1'b0;
         q_cnt_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         if (push) begin
            q_wr_ff <= ~q_wr_ff;
         end
         if (pop) begin
            q_rd_ff <= ~q_rd_ff;
         end
         q_cnt_ff <= q_cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      if (push) begin
         q_ff[q_wr_ff] <= cur_ff;
      end
   end

   assign job_valid = (q_cnt_ff != 2'd0);
   assign job       = q_ff[q_rd_ff];

endmodule

FILE: hw/rtl/fnvht_back.sv
// Back: probes the slot memory one slot at a time (read, then check), grows the table
// by rehashing into the other bank, and issues the reply beat.
// After reset both banks are swept over all MAX_CAPACITY slots to clear valid bits.
module fnvht_back #(
   parameter int MAX_CAPACITY     = 1024,
   parameter int INITIAL_CAPACITY = 256,
   parameter int VALUE_WIDTH      = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  fnvht_pkg::job_type   job,
   output logic                 pop,
   output logic                 rsp_done,
   output logic [2:0]           rsp_status,
   output logic [31:0]          rsp_value_out,
   output logic [10:0]          rsp_count_out
);

   localparam int AW = $clog2(MAX_CAPACITY);
   localparam int CW = AW + 1;

   // Two banks: growth rehashes from the active bank into the other one.
   // Word: {valid, key, len, value}. Growth clears each old slot after
   // reading it, so the idle bank is empty whenever a growth begins.
   localparam int DW = 1 + 64 + 4 + VALUE_WIDTH;
   logic [DW-1:0] mem0 [MAX_CAPACITY];
   logic [DW-1:0] mem1 [MAX_CAPACITY];

   fnvht_pkg::back_state_type state_ff, state_in;
   fnvht_pkg::job_type cur_ff;
   logic         bank_ff;
   logic [CW-1:0] cap_ff;
   logic [CW-1:0] cnt_ff;
   logic [AW-1:0] clr_ff;
   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [AW-1:0] gsrc_ff;
   logic [CW-1:0] gleft_ff;
   logic [DW-1:0] rd_ff;
   logic [DW-1:0] gent_ff;
   logic [63:0]   gh_ff;
   logic [3:0]    gi_ff;
   logic [2:0]    st_ff;
   logic [31:0]   vo_ff;

   logic [AW-1:0] cap_mask;
   logic [AW-1:0] rd_addr;
   logic          rd_bank;
   logic          rd_valid;
   logic          wr_en, wr_bank, wr_both;
   logic [AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic          key_eq;
   logic [AW-1:0] idx_nxt;
   logic [63:0]   gkey;
   logic [63:0]   gmul;
   logic [VALUE_WIDTH-1:0] vstore;

   assign cap_mask = AW'(cap_ff - CW'(1));
   assign rd_valid = rd_ff[DW-1];
   assign key_eq   = (rd_ff[DW-2 -: 64] == cur_ff.key) && (rd_ff[DW-66 -: 4] == cur_ff.len);
   assign idx_nxt  = ((CW'(idx_ff) + CW'(1)) >= cap_ff) ? '0 : idx_ff + AW'(1);
   assign gkey     = gent_ff[DW-2 -: 64];
   assign gmul     = fnvht_pkg::fnv_step(gh_ff, gkey[{gi_ff[2:0], 3'b000} +: 8]);
   assign vstore   = VALUE_WIDTH'(cur_ff.value);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      steps_in = steps_ff;
      pop      = 1'b0;
      rd_addr  = idx_ff;
      rd_bank  = bank_ff;
      wr_en    = 1'b0;
      wr_bank  = bank_ff;
      wr_both  = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = {1'b1, cur_ff.key, cur_ff.len, vstore};
      unique case (state_ff)
         fnvht_pkg::BS_CLEAR: begin
            wr_en   = 1'b1;
            wr_both = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            if (clr_ff == AW'(MAX_CAPACITY - 1)) begin
               state_in = fnvht_pkg::BS_IDLE;
            end
         end
         fnvht_pkg::BS_IDLE: begin
            if (job_valid) begin
               pop      = 1'b1;
               state_in = fnvht_pkg::BS_DECIDE;
            end
         end
         fnvht_pkg::BS_DECIDE: begin
            idx_in   = AW'(cur_ff.hash) & cap_mask;
            steps_in = '0;
            if (!cur_ff.is_set) begin
               state_in = fnvht_pkg::BS_PROBE_RD;
            end else if (cur_ff.zero_val) begin
               state_in = fnvht_pkg::BS_REPLY;
            end else if (cnt_ff >= (cap_ff >> 1)) begin
               if (({1'b0, cap_ff} << 1) > (CW+1)'(MAX_CAPACITY)) begin
                  state_in = fnvht_pkg::BS_REPLY;
               end else begin
                  state_in = fnvht_pkg::BS_GROW_RD;
               end
            end else begin
               state_in = fnvht_pkg::BS_PROBE_RD;
            end
         end
         fnvht_pkg::BS_PROBE_RD: begin
            state_in = fnvht_pkg::BS_PROBE_CHK;
         end
         fnvht_pkg::BS_PROBE_CHK: begin
            if (!rd_valid) begin
               if (cur_ff.is_set) begin
                  wr_en = 1'b1;
               end
               state_in = fnvht_pkg::BS_REPLY;
            end else if (key_eq) begin
               if (cur_ff.is_set) begin
                  wr_en   = 1'b1;
                  wr_data = {rd_ff[DW-1 -: 69], vstore};
               end
               state_in = fnvht_pkg::BS_REPLY;
            end else if (steps_ff + CW'(1) >= cap_ff) begin
               state_in = fnvht_pkg::BS_REPLY;
            end else begin
               steps_in = steps_ff + CW'(1);
               idx_in   = idx_nxt;
               state_in = fnvht_pkg::BS_PROBE_RD;
            end
         end
         fnvht_pkg::BS_GROW_RD: begin
            rd_addr  = gsrc_ff;
            state_in = fnvht_pkg::BS_GROW_CHK;
         end
         fnvht_pkg::BS_GROW_CHK: begin
            // old slot is consumed: leave it empty for the next growth
            wr_en    = 1'b1;
            wr_addr  = gsrc_ff;
            wr_data  = '0;
            state_in = rd_valid ? fnvht_pkg::BS_GROW_HASH : fnvht_pkg::BS_GROW_NEXT;
         end
         fnvht_pkg::BS_GROW_HASH: begin
            if (gi_ff >= gent_ff[DW-66 -: 4]) begin
               idx_in   = AW'(gh_ff) & AW'((cap_ff << 1) - CW'(1));
               state_in = fnvht_pkg::BS_GROW_PRB_RD;
            end
         end
         fnvht_pkg::BS_GROW_PRB_RD: begin
            rd_bank  = ~bank_ff;
            state_in = fnvht_pkg::BS_GROW_PRB_CHK;
         end
         fnvht_pkg::BS_GROW_PRB_CHK: begin
            if (!rd_valid) begin
               wr_en    = 1'b1;
               wr_bank  = ~bank_ff;
               wr_data  = gent_ff;
               state_in = fnvht_pkg::BS_GROW_NEXT;
            end else begin
               idx_in   = ((CW'(idx_ff) + CW'(1)) >= (cap_ff << 1)) ? '0 : idx_ff + AW'(1);
               state_in = fnvht_pkg::BS_GROW_PRB_RD;
            end
         end
         fnvht_pkg::BS_GROW_NEXT: begin
            if (gleft_ff == CW'(1)) begin
               idx_in   = AW'(cur_ff.hash) & AW'((cap_ff << 1) - CW'(1));
               steps_in = '0;
               state_in = fnvht_pkg::BS_PROBE_RD;
            end else begin
               state_in = fnvht_pkg::BS_GROW_RD;
            end
         end
         fnvht_pkg::BS_REPLY: begin
            state_in = fnvht_pkg::BS_IDLE;
         end
         default: state_in = fnvht_pkg::BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fnvht_pkg::BS_CLEAR;
         clr_ff   <= '0;
         bank_ff  <= 1'b0;
         cap_ff   <= CW'(INITIAL_CAPACITY);
         cnt_ff   <= '0;
         st_ff    <= fnvht_pkg::ST_MISS;
         vo_ff    <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            fnvht_pkg::BS_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
            end
            fnvht_pkg::BS_DECIDE: begin
               vo_ff <= '0;
               if (cur_ff.is_set && cur_ff.zero_val) begin
                  st_ff <= fnvht_pkg::ST_ZERO;
               end else begin
                  st_ff <= cur_ff.is_set ? fnvht_pkg::ST_FULL : fnvht_pkg::ST_MISS;
               end
            end
            fnvht_pkg::BS_PROBE_CHK: begin
               if (!rd_valid && cur_ff.is_set) begin
                  st_ff  <= fnvht_pkg::ST_INSERTED;
                  cnt_ff <= cnt_ff + CW'(1);
               end else if (rd_valid && key_eq) begin
                  st_ff <= cur_ff.is_set ? fnvht_pkg::ST_UPDATED : fnvht_pkg::ST_HIT;
                  if (!cur_ff.is_set) begin
                     vo_ff <= 32'(rd_ff[VALUE_WIDTH-1:0]);
                  end
               end
            end
            fnvht_pkg::BS_GROW_NEXT: begin
               if (gleft_ff == CW'(1)) begin
                  bank_ff <= ~bank_ff;
                  cap_ff  <= cap_ff << 1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      steps_ff <= steps_in;
      if (pop) begin
         cur_ff <= job;
      end
      rd_ff <= rd_bank ? mem1[rd_addr] : mem0[rd_addr];
      if (wr_en && (wr_both || wr_bank)) begin
         mem1[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_both || !wr_bank)) begin
         mem0[wr_addr] <= wr_data;
      end
      unique case (state_ff)
         fnvht_pkg::BS_DECIDE: begin
            gsrc_ff  <= '0;
            gleft_ff <= cap_ff;
         end
         fnvht_pkg::BS_GROW_CHK: begin
            gent_ff <= rd_ff;
            gh_ff   <= fnvht_pkg::FNV_BASIS;
            gi_ff   <= '0;
         end
         fnvht_pkg::BS_GROW_HASH: begin
            if (gi_ff < gent_ff[DW-66 -: 4]) begin
               gh_ff <= gmul;
               gi_ff <= gi_ff + 4'd1;
            end
         end
         fnvht_pkg::BS_GROW_NEXT: begin
            gsrc_ff  <= gsrc_ff + AW'(1);
            gleft_ff <= gleft_ff - CW'(1);
         end
         default: begin
         end
      endcase
   end

   assign rsp_done      = (state_ff == fnvht_pkg::BS_REPLY);
   assign rsp_status    = st_ff;
   assign rsp_value_out = vo_ff;
   assign rsp_count_out = 11'(cnt_ff);

endmodule

FILE: hw/rtl/fnvht_checker.sv
`include "assert_macros.svh"

module fnvht_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_done,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_value_out,
   input logic [10:0] rsp_count_out
);

   logic miss_beat;

   assign miss_beat = rsp_done && (rsp_status != fnvht_pkg::ST_HIT);

   `CHK_IMPLY(a_status_range, clock, reset, rsp_done, rsp_status <= fnvht_pkg::ST_FULL, "bad status")
   `CHK_IMPLY(a_value_only_hit, clock, reset, miss_beat, rsp_value_out == 32'd0, "value on miss")
   `CHK_NEXT(a_start_busy, clock, reset, start && !busy, busy, "accept did not raise busy")
   `CHK_NEXT(a_count_step, clock, reset, rsp_done, rsp_count_out <= $past(rsp_count_out) + 11'd1, "count jumped")

endmodule

bind fnv1a_linear_probe_hash_table fnvht_checker u_chk (.*);

FILE: bench/tb_fnv1a_linear_probe_hash_table.sv
module tb_fnv1a_linear_probe_hash_table;

   localparam int TBL_MAX    = 1024;
   localparam int TBL_INIT   = 256;
   localparam int CYCLE_CAP  = 1000000;
   localparam int RAND_BEATS = 436;

   typedef struct {
      fnvht_pkg::opcode_type op;
      logic [63:0] key;
      logic [3:0]  len;
      logic [31:0] val;
      bit          drain;   // not a beat: wait here until every answer is back
   } request_type;

   typedef struct {
      fnvht_pkg::status_type st;
      logic [31:0] val;
      logic [10:0] cnt;
   } answer_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_opcode;
   logic [63:0] req_key_bytes;
   logic [3:0]  req_key_len;
   logic [31:0] req_value_in;
   logic        rsp_done;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_value_out;
   logic [10:0] rsp_count_out;

   fnv1a_linear_probe_hash_table uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_key_bytes(req_key_bytes),
      .req_key_len(req_key_len), .req_value_in(req_value_in),
      .rsp_done(rsp_done), .rsp_status(rsp_status),
      .rsp_value_out(rsp_value_out), .rsp_count_out(rsp_count_out)
   );

   // Stimulus queue, filled up front; answers still owed by the block.
   request_type pending_q[$];
   answer_type  owed_q[$];
   request_type cur_req;

   // Shadow copy of the table contents.
   logic [63:0] sh_key[TBL_MAX];
   logic [3:0]  sh_len[TBL_MAX];
   bit          sh_valid[TBL_MAX];
   logic [31:0] sh_val[TBL_MAX];
   int          sh_cap = TBL_INIT;
   int          sh_count = 0;

   int errors = 0;
   int cycles = 0;
   int gap_left;
   int burst_left;

   // Key pool for hits and updates.
   logic [63:0] pool_key[$];
   logic [3:0]  pool_len[$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] fnv1a64(logic [63:0] k, int n);
      logic [63:0] h;
      h = 64'hCBF29CE484222325;
      for (int i = 0; i < n; i++) begin
         h = h ^ {56'd0, k[8*i +: 8]};
         h = h * 64'h00000100000001B3;
      end
      return h;
   endfunction

   // 1 = match, 0 = empty slot found, -1 = wrapped all the way round.
   function automatic int probe_slot(logic [63:0] k, logic [3:0] n, int cap,
                                     output int where);
      int idx;
      where = 0;
      idx = int'(fnv1a64(k, n) & 64'(cap - 1)) % cap;
      for (int i = 0; i < cap; i++) begin
         if (!sh_valid[idx]) begin
            where = idx;
            return 0;
         end
         if (sh_len[idx] == n && sh_key[idx] == k) begin
            where = idx;
            return 1;
         end
         idx = (idx + 1 >= cap) ? 0 : idx + 1;
      end
      return -1;
   endfunction

   function automatic bit double_table();
      logic [63:0] tk[$];
      logic [3:0]  tl[$];
      logic [31:0] tv[$];
      int          w;
      if (sh_cap * 2 > TBL_MAX) return 0;
      for (int i = 0; i < sh_cap; i++)
         if (sh_valid[i]) begin
            tk.push_back(sh_key[i]);
            tl.push_back(sh_len[i]);
            tv.push_back(sh_val[i]);
         end
      for (int i = 0; i < TBL_MAX; i++) sh_valid[i] = 0;
      sh_cap = sh_cap * 2;
      foreach (tk[i])
         if (probe_slot(tk[i], tl[i], sh_cap, w) == 0) begin
            sh_valid[w] = 1;
            sh_key[w]   = tk[i];
            sh_len[w]   = tl[i];
            sh_val[w]   = tv[i];
         end
      return 1;
   endfunction

   // Applies one request to the shadow table and returns the answer it owes.
   function automatic answer_type lookup_or_store(request_type r);
      answer_type  a;
      logic [3:0]  n;
      logic [63:0] k;
      int          w, hit;
      n = (r.len > 4'd8) ? 4'd8 : r.len;
      k = r.key;
      if (n < 8) k = k & ((64'd1 << (8 * n)) - 64'd1);
      a.val = '0;
      if (r.op == fnvht_pkg::OP_GET) begin
         hit  = probe_slot(k, n, sh_cap, w);
         a.st = (hit == 1) ? fnvht_pkg::ST_HIT : fnvht_pkg::ST_MISS;
         if (hit == 1) a.val = sh_val[w];
      end else if (r.val == 0) begin
         a.st = fnvht_pkg::ST_ZERO;
      end else if (sh_count >= sh_cap / 2 && !double_table()) begin
         a.st = fnvht_pkg::ST_FULL;
      end else begin
         hit = probe_slot(k, n, sh_cap, w);
         if (hit == 1) begin
            sh_val[w] = r.val;
            a.st      = fnvht_pkg::ST_UPDATED;
         end else if (hit == 0) begin
            sh_valid[w] = 1;
            sh_key[w]   = k;
            sh_len[w]   = n;
            sh_val[w]   = r.val;
            sh_count++;
            a.st = fnvht_pkg::ST_INSERTED;
         end else begin
            a.st = fnvht_pkg::ST_FULL;
         end
      end
      a.cnt = 11'(sh_count);
      return a;
   endfunction

   task automatic add_req(fnvht_pkg::opcode_type op, logic [63:0] k, logic [3:0] n,
                          logic [31:0] v);
      request_type r;
      r.op = op; r.key = k; r.len = n; r.val = v; r.drain = 0;
      pending_q.push_back(r);
      if (op == fnvht_pkg::OP_SET && v != 0) begin
         pool_key.push_back(k);
         pool_len.push_back(n);
      end
   endtask

   // Stimulus: directed corners, then mostly fresh inserts with hits/updates
   // mixed in so the table grows twice.
   initial begin
      request_type hold;
      logic [63:0] k;
      int          pick, sel;
      hold = '{fnvht_pkg::OP_GET, '0, '0, '0, 1'b1};

      add_req(fnvht_pkg::OP_GET, 64'h0, 4'd0, 32'h0);              // empty table miss
      add_req(fnvht_pkg::OP_SET, 64'h0, 4'd0, 32'hFFFF_FFFF);      // empty key
      add_req(fnvht_pkg::OP_GET, 64'h0, 4'd0, 32'h1234);           // hit on empty key
      add_req(fnvht_pkg::OP_SET, 64'h0, 4'd1, 32'h1);              // zero byte differs by length
      add_req(fnvht_pkg::OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h8000_0000);
      add_req(fnvht_pkg::OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h5A5A_A5A5); // clamps
      add_req(fnvht_pkg::OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 32'h0);
      add_req(fnvht_pkg::OP_SET, 64'hDEAD_BEEF_0012_3456, 4'd3, 32'h77); // stray bytes
      add_req(fnvht_pkg::OP_GET, 64'h0000_0000_0012_3456, 4'd3, 32'h0);
      add_req(fnvht_pkg::OP_SET, 64'h0000_0000_0012_3456, 4'd3, 32'h0); // zero refused
      add_req(fnvht_pkg::OP_GET, 64'hAAAA_AAAA_AAAA_AAAA, 4'd8, 32'h0); // miss
      add_req(fnvht_pkg::OP_GET, 64'h5555_5555_5555_5555, 4'd7, 32'h0);
      pending_q.push_back(hold);                                    // full drain once
      add_req(fnvht_pkg::OP_SET, 64'h5555_5555_5555_5555, 4'd4, 32'hFFFF_FFFE);
      add_req(fnvht_pkg::OP_GET, 64'hAAAA_AAAA_5555_5555, 4'd4, 32'hFFFF_FFFF);

      for (int i = 0; i < RAND_BEATS; i++) begin
         sel = $urandom_range(99);
         k   = {$urandom, $urandom};
         if (sel < 72) begin
            add_req(fnvht_pkg::OP_SET, k, 4'($urandom_range(8)), $urandom | 32'h1);
         end else if (sel < 90 && pool_key.size() > 0) begin
            pick = $urandom_range(pool_key.size() - 1);
            // reuse a stored key, sometimes with garbage above its length
            k = ($urandom_range(1)) ? pool_key[pick] | (k << (8 * pool_len[pick]))
                                    : pool_key[pick];
            if (pool_len[pick] == 0) k = pool_key[pick];
            add_req(fnvht_pkg::opcode_type'($urandom_range(1)), k, pool_len[pick],
                    $urandom | 32'h2);
         end else begin
            add_req(fnvht_pkg::opcode_type'($urandom_range(1)), k, 4'($urandom_range(15)),
                    ($urandom_range(2) == 0) ? 32'h0 : $urandom);
         end
      end
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver: bursts of beats separated by random gaps.
   always @(posedge clock) begin
      logic fire;
      fire = start && !busy;
      if (reset) begin
         start <= 1'b0; req_opcode <= 1'b0; req_key_bytes <= '0;
         req_key_len <= '0; req_value_in <= '0;
         gap_left <= 0; burst_left <= 4;
      end else begin
         if (fire) owed_q.push_back(lookup_or_store(cur_req));
         if (start && !fire) begin
            // beat still waiting for busy to drop
         end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_q.size() > 0 && pending_q[0].drain) begin
            start <= 1'b0;
            if (owed_q.size() == 0) void'(pending_q.pop_front());
         end else if (pending_q.size() > 0) begin
            cur_req        = pending_q.pop_front();
            start         <= 1'b1;
            req_opcode    <= cur_req.op;
            req_key_bytes <= cur_req.key;
            req_key_len   <= cur_req.len;
            req_value_in  <= cur_req.val;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobe must match the oldest owed answer.
   always @(posedge clock) begin
      answer_type a;
      if (!reset && rsp_done) begin
         if (owed_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected answer: status %0d", rsp_status);
         end else begin
            a = owed_q.pop_front();
            if (rsp_status !== a.st || rsp_value_out !== a.val || rsp_count_out !== a.cnt) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp st %0d val %h cnt %0d, got st %0d val %h cnt %0d",
                           a.st, a.val, a.cnt, rsp_status, rsp_value_out, rsp_count_out);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_CAP) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      @(negedge reset);
      wait (pending_q.size() == 0 && !start && owed_q.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && owed_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
